[sv/ptree_pkg.sv]
package ptree_pkg;

    localparam int MAX_LEN  = 4096;
    localparam int ALPHABET = 26;
    localparam int NODE_CAP = MAX_LEN + 2;
    localparam int CHILD_DEPTH = NODE_CAP * ALPHABET;

    localparam int SYM_W  = 5;
    localparam int ID_W   = $clog2(NODE_CAP);
    localparam int POS_W  = $clog2(MAX_LEN + 1);
    localparam int LEN_W  = POS_W + 1;
    localparam int CADR_W = $clog2(CHILD_DEPTH);
    localparam int OUT_W  = 13;

    typedef logic [ID_W-1:0]   t_id;
    typedef logic [SYM_W-1:0]  t_sym;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic signed [LEN_W-1:0] t_len;
    typedef logic [CADR_W-1:0] t_cadr;

    // one node entry: link, length and the (parent, symbol) edge that made it
    typedef struct packed {
        t_id  link;
        t_len len;
        t_id  parent;
        t_sym psym;
    } t_node;

    function automatic t_cadr child_addr(input t_id node, input t_sym sym);
        child_addr = CADR_W'(node) * CADR_W'(ALPHABET) + CADR_W'(sym);
    endfunction

endpackage

[sv/palindromic_tree_insert.sv]
// Palindromic tree (eertree) insertion, one lower-case symbol per request.
// Input channel: i_in_valid / o_in_ready with i_symbol (0..25, larger codes
// saturate to 25) and i_first, which clears the tree and text before the
// symbol is taken. Output channel: o_out_valid / i_out_ready with o_pal_len,
// o_node_id, o_created and o_overflow, exactly one result per request.
// Each suffix-link step is a node memory read, a text memory read and a
// compare. A request then reads the child memory and checks the child
// node that it names. When a node is created, a second suffix-link walk
// from the parent's link finds the new node's link (skipped when it hangs
// off the odd root) before the node and child entries are written; the
// steps are amortised constant. One request is in work at a time; the next
// is taken once its result is in the output register.
// Reset leaves an empty tree (only the two roots) and an empty text; no
// memory clearing pass is needed, as child entries are checked against the
// parent and symbol recorded in the node they point to. Once 4096 symbols
// are held, further symbols are dropped with o_overflow set. A stalled
// receiver holds the result in the output register and the block finishes
// the following request up to its result, then waits.
module palindromic_tree_insert (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [4:0]                i_symbol,
    input  logic                      i_first,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [12:0]               o_pal_len,
    output logic [12:0]               o_node_id,
    output logic                      o_created,
    output logic                      o_overflow
);
    import ptree_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RDN  = 4'd1;
    localparam logic [3:0] S_RDT  = 4'd2;
    localparam logic [3:0] S_CHK  = 4'd3;
    localparam logic [3:0] S_CRD  = 4'd4;
    localparam logic [3:0] S_CQ   = 4'd5;
    localparam logic [3:0] S_CV   = 4'd6;
    localparam logic [3:0] S_WR   = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    localparam logic [1:0] EX_NO  = 2'd0;
    localparam logic [1:0] EX_YES = 2'd1;
    localparam logic [1:0] EX_MEM = 2'd2;

    localparam t_id ROOT_EVEN = t_id'(0);
    localparam t_id ROOT_ODD  = t_id'(1);

    // memories
    t_sym  text_mem  [0:MAX_LEN];
    t_node node_mem  [0:NODE_CAP-1];
    t_id   child_mem [0:CHILD_DEPTH-1];

    logic  [3:0] r_state;
    t_id   r_count, r_last, r_cur, r_u, r_ulink, r_clink, r_c, r_link;
    t_len  r_ulen, r_clen;
    t_pos  r_pos, r_n;
    t_sym  r_sym;
    logic  r_phase, r_nroot, r_nroot_id;
    logic  [1:0] r_ext;
    t_sym  r_tq;
    t_node r_nq;
    t_id   r_cq;
    logic  [OUT_W-1:0] r_res_len, r_res_node;
    logic  r_res_created, r_res_ovf;
    logic  r_ovalid;
    logic  [OUT_W-1:0] r_opal, r_onode;
    logic  r_ocreated, r_oovf;

    logic  accept;
    t_sym  sym_sat;
    t_pos  pos_eff;
    logic  text_we;
    t_pos  text_wa, text_ra;
    t_id   node_ra;
    logic  node_we;
    t_node node_wd;
    t_cadr child_ra, child_wa;
    logic  child_we;
    t_node nd;
    logic signed [LEN_W:0] idx;
    logic  ext_ok, child_ok;
    t_id   new_id;
    t_len  new_len;
    logic  out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign sym_sat     = (i_symbol >= t_sym'(ALPHABET)) ? t_sym'(ALPHABET - 1) : i_symbol;
    assign pos_eff     = i_first ? '0 : r_pos;
    assign out_free    = !r_ovalid || i_out_ready;

    assign o_out_valid = r_ovalid;
    assign o_pal_len   = r_opal;
    assign o_node_id   = r_onode;
    assign o_created   = r_ocreated;
    assign o_overflow  = r_oovf;

    // node data of the last node read; roots are constants
    always_comb begin
        nd = r_nq;
        if (r_nroot) begin
            nd.parent = '0;
            nd.psym   = '0;
            if (r_nroot_id) begin
                nd.link = ROOT_EVEN;
                nd.len  = t_len'(-1);
            end else begin
                nd.link = ROOT_ODD;
                nd.len  = '0;
            end
        end
    end

    assign idx      = (LEN_W+1)'({2'b00, r_n}) - (LEN_W+1)'(nd.len) - (LEN_W+1)'(1);
    assign ext_ok   = (r_ext == EX_YES) || ((r_ext == EX_MEM) && (r_tq == r_sym));
    assign child_ok = (r_c >= t_id'(2)) && (r_c <= r_count)
                   && (nd.parent == r_cur) && (nd.psym == r_sym);
    assign new_id   = r_count + t_id'(1);
    assign new_len  = r_ulen + t_len'(2);

    always_comb begin
        text_we  = accept && (pos_eff < t_pos'(MAX_LEN));
        text_wa  = pos_eff + t_pos'(1);
        text_ra  = idx[POS_W-1:0];
        node_ra  = (r_state == S_CQ) ? ((r_cq < t_id'(NODE_CAP)) ? r_cq : '0) : r_cur;
        node_we  = (r_state == S_WR);
        node_wd  = '{link: r_link, len: new_len, parent: r_u, psym: r_sym};
        child_ra = child_addr(r_cur, r_sym);
        child_wa = child_addr(r_u, r_sym);
        child_we = (r_state == S_WR);
    end

    always_ff @(posedge i_clk) begin
        if (text_we) begin
            text_mem[text_wa] <= sym_sat;
        end
        r_tq <= text_mem[text_ra];
    end

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            node_mem[new_id] <= node_wd;
        end
        r_nq <= node_mem[node_ra];
    end

    always_ff @(posedge i_clk) begin
        if (child_we) begin
            child_mem[child_wa] <= new_id;
        end
        r_cq <= child_mem[child_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= ROOT_ODD;
            r_last   <= ROOT_EVEN;
            r_pos    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if ((r_state == S_OUT) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_sym <= sym_sat;
                        if (i_first) begin
                            r_count <= ROOT_ODD;
                            r_last  <= ROOT_EVEN;
                        end
                        if (pos_eff >= t_pos'(MAX_LEN)) begin
                            r_pos         <= pos_eff;
                            r_res_len     <= '0;
                            r_res_node    <= '0;
                            r_res_created <= 1'b0;
                            r_res_ovf     <= 1'b1;
                            r_state       <= S_OUT;
                        end else begin
                            r_pos   <= pos_eff + t_pos'(1);
                            r_n     <= pos_eff + t_pos'(1);
                            r_cur   <= i_first ? ROOT_EVEN : r_last;
                            r_phase <= 1'b0;
                            r_state <= S_RDN;
                        end
                    end
                end
                S_RDN: begin
                    r_nroot    <= (r_cur < t_id'(2));
                    r_nroot_id <= r_cur[0];
                    r_state    <= S_RDT;
                end
                S_RDT: begin
                    // position n - len - 1; the sentinel at 0 never matches
                    if (idx <= 0) begin
                        r_ext <= EX_NO;
                    end else if (idx == (LEN_W+1)'({2'b00, r_n})) begin
                        r_ext <= EX_YES;
                    end else begin
                        r_ext <= EX_MEM;
                    end
                    r_clink <= nd.link;
                    r_clen  <= nd.len;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (ext_ok || (r_cur == ROOT_ODD)) begin
                        if (!r_phase) begin
                            r_u     <= r_cur;
                            r_ulen  <= r_clen;
                            r_ulink <= r_clink;
                        end
                        r_state <= S_CRD;
                    end else begin
                        r_cur   <= r_clink;
                        r_state <= S_RDN;
                    end
                end
                S_CRD: begin
                    r_state <= S_CQ;
                end
                S_CQ: begin
                    r_c        <= r_cq;
                    r_nroot    <= (r_cq < t_id'(2));
                    r_nroot_id <= r_cq[0];
                    r_state    <= S_CV;
                end
                S_CV: begin
                    if (r_phase) begin
                        r_link  <= child_ok ? r_c : ROOT_EVEN;
                        r_state <= S_WR;
                    end else if (child_ok) begin
                        r_last        <= r_c;
                        r_res_len     <= nd.len[OUT_W-1:0];
                        r_res_node    <= OUT_W'(r_c);
                        r_res_created <= 1'b0;
                        r_res_ovf     <= 1'b0;
                        r_state       <= S_OUT;
                    end else if (32'(r_count) + 32'd1 < 32'(NODE_CAP)) begin
                        if (r_u == ROOT_ODD) begin
                            r_link  <= ROOT_EVEN;
                            r_state <= S_WR;
                        end else begin
                            r_cur   <= r_ulink;
                            r_phase <= 1'b1;
                            r_state <= S_RDN;
                        end
                    end else begin
                        // tree full: falls back to the even root
                        r_last        <= ROOT_EVEN;
                        r_res_len     <= '0;
                        r_res_node    <= '0;
                        r_res_created <= 1'b0;
                        r_res_ovf     <= 1'b0;
                        r_state       <= S_OUT;
                    end
                end
                S_WR: begin
                    r_count       <= new_id;
                    r_last        <= new_id;
                    r_res_len     <= new_len[OUT_W-1:0];
                    r_res_node    <= OUT_W'(new_id);
                    r_res_created <= 1'b1;
                    r_res_ovf     <= 1'b0;
                    r_state       <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_opal     <= r_res_len;
                        r_onode    <= r_res_node;
                        r_ocreated <= r_res_created;
                        r_oovf     <= r_res_ovf;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[sim/palindromic_tree_insert_checker.sv]
module palindromic_tree_insert_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [4:0]  i_symbol,
    input  logic        i_first,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [12:0] i_pal_len,
    input  logic [12:0] i_node_id,
    input  logic        i_created,
    input  logic        i_overflow,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ptree_pkg::*;

    typedef struct packed {
        logic [12:0] pal_len;
        logic [12:0] node_id;
        logic        created;
        logic        overflow;
    } t_answer;

    t_answer     answer_q[$];
    logic [4:0]  text_mem[MAX_LEN+1];
    int          kids[NODE_CAP][ALPHABET];
    int          link_of[NODE_CAP];
    int          len_of[NODE_CAP];
    int          nodes_used;
    int          tail_node;
    int          text_pos;
    int          fails = 0;

    assign o_pending = answer_q.size();
    assign o_fail_count = fails;

    function automatic void tree_wipe();
        for (int i = 0; i < 2; i++)
            for (int s = 0; s < ALPHABET; s++)
                kids[i][s] = 0;
        len_of[0] = 0;
        link_of[0] = 1;
        len_of[1] = -1;
        link_of[1] = 0;
        nodes_used = 1;
        tail_node = 0;
        text_pos = 0;
    endfunction

    function automatic bit mirrors(int node, int n, logic [4:0] sym);
        int idx;
        idx = n - len_of[node] - 1;
        if (idx <= 0 || idx > n)
            return 0;
        return text_mem[idx] == sym;
    endfunction

    function automatic int climb(int node, int n, logic [4:0] sym);
        while (!mirrors(node, n, sym) && node != 1)
            node = link_of[node];
        return node;
    endfunction

    function automatic t_answer insert_symbol(logic [4:0] raw, logic clr);
        t_answer    a;
        logic [4:0] sym;
        int         n;
        int         u;
        int         hit;
        bit         made;
        sym = (raw >= ALPHABET) ? 5'(ALPHABET - 1) : raw;
        made = 0;
        if (clr)
            tree_wipe();
        if (text_pos >= MAX_LEN) begin
            a = '{13'd0, 13'd0, 1'b0, 1'b1};
            return a;
        end
        n = text_pos + 1;
        text_pos = n;
        text_mem[n] = sym;
        u = climb(tail_node, n, sym);
        hit = kids[u][sym];
        if (hit == 0 && nodes_used + 1 < NODE_CAP) begin
            nodes_used++;
            hit = nodes_used;
            for (int s = 0; s < ALPHABET; s++)
                kids[hit][s] = 0;
            len_of[hit] = len_of[u] + 2;
            link_of[hit] = (u == 1) ? 0 : kids[climb(link_of[u], n, sym)][sym];
            kids[u][sym] = hit;
            made = 1;
        end
        tail_node = hit;
        a.pal_len = 13'(len_of[hit]);
        a.node_id = 13'(hit);
        a.created = made;
        a.overflow = 1'b0;
        return a;
    endfunction

    initial begin
        tree_wipe();
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready)
                answer_q.push_back(insert_symbol(i_symbol, i_first));
            if (i_out_valid && i_out_ready) begin
                if (answer_q.size() == 0) begin
                    $error("unexpected result");
                    fails++;
                end else begin
                    want = answer_q.pop_front();
                    if (i_pal_len !== want.pal_len) begin
                        $error("pal_len expected %0d got %0d", want.pal_len, i_pal_len);
                        fails++;
                    end
                    if (i_node_id !== want.node_id) begin
                        $error("node_id expected %0d got %0d", want.node_id, i_node_id);
                        fails++;
                    end
                    if (i_created !== want.created) begin
                        $error("created expected %0d got %0d", want.created, i_created);
                        fails++;
                    end
                    if (i_overflow !== want.overflow) begin
                        $error("overflow expected %0d got %0d", want.overflow, i_overflow);
                        fails++;
                    end
                end
            end
        end
    end
endmodule

[sim/palindromic_tree_insert_tb.sv]
module palindromic_tree_insert_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ptree_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [4:0]  symbol = '0;
    logic        first = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [12:0] pal_len;
    logic [12:0] node_id;
    logic        created;
    logic        overflow;
    int          fail_count;
    int          pending;
    bit          long_hold = 0;

    always #2 clk = ~clk;

    palindromic_tree_insert u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_symbol(symbol), .i_first(first),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_pal_len(pal_len), .o_node_id(node_id),
        .o_created(created), .o_overflow(overflow)
    );

    palindromic_tree_insert_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_symbol(symbol), .i_first(first),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_pal_len(pal_len), .i_node_id(node_id),
        .i_created(created), .i_overflow(overflow),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // one request; the gap before it is drawn per request
    task automatic send_symbol(input logic [4:0] sym, input logic clr);
        int gap;
        gap = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        symbol <= sym;
        first <= clr;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
    endtask

    // receiver: random stalls, plus one long hold-off
    initial begin
        int wait_n;
        bit held;
        held = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (long_hold && !held) begin
                out_ready <= 1'b0;
                repeat (200) @(posedge clk);
                held = 1;
            end
            wait_n = $urandom_range(0, 3);
            if (wait_n != 0) begin
                out_ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid && !(long_hold && !held)) @(posedge clk);
        end
    end

    initial begin
        #20ms;
        $display("palindromic_tree_insert test failed");
        $finish;
    end

    initial begin
        int sent;
        int len;
        logic [4:0] word[64];
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, out-of-alphabet codes, classic strings
        send_symbol(5'd0, 1'b1);
        send_symbol(5'd0, 1'b0);
        send_symbol(5'd0, 1'b0);
        send_symbol(5'd25, 1'b0);
        send_symbol(5'd31, 1'b0);
        send_symbol(5'd26, 1'b0);
        send_symbol(5'd0, 1'b0);
        send_symbol(5'd1, 1'b1);
        send_symbol(5'd0, 1'b0);
        send_symbol(5'd1, 1'b0);
        send_symbol(5'd0, 1'b0);
        send_symbol(5'd1, 1'b0);
        send_symbol(5'd2, 1'b0);
        send_symbol(5'd1, 1'b0);
        send_symbol(5'd0, 1'b0);
        send_symbol(5'd21, 1'b0);
        send_symbol(5'd10, 1'b0);
        drain();

        // hold the output so the block backs up its input
        long_hold = 1;
        for (int i = 0; i < 6; i++)
            send_symbol(5'($urandom_range(0, 2)), 1'b0);
        drain();

        // fill the text past capacity: runs of one symbol build long palindromes
        send_symbol(5'd3, 1'b1);
        for (int i = 1; i < MAX_LEN + 3; i++)
            send_symbol((i % 512 < 400) ? 5'd3 : 5'($urandom_range(0, 31)), 1'b0);
        send_symbol(5'd4, 1'b1);
        send_symbol(5'd4, 1'b0);
        drain();

        // random: mostly mirrored words over small alphabets
        sent = 0;
        while (sent < 1550) begin
            len = $urandom_range(1, 30);
            for (int i = 0; i < len; i++)
                word[i] = 5'($urandom_range(0, $urandom_range(1, 3) == 1 ? 31 : 3));
            for (int i = 0; i < 2 * len; i++) begin
                send_symbol(i < len ? word[i] : word[2 * len - 1 - i],
                            ($urandom_range(0, 60) == 0));
                sent++;
            end
            if ($urandom_range(0, 40) == 0)
                drain();
        end

        drain();
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("palindromic_tree_insert test passed");
        else
            $display("palindromic_tree_insert test failed");
        $finish;
    end
endmodule
